FILE: hw/rtl/hspd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// hspd_pkg
// Types, codes and helpers shared by the humidity sensor pulse decoder and
// its checker.
// ============================================================================
package hspd_pkg;

    localparam int unsigned CFG_W       = 12;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned TIME_W      = 16;
    localparam int unsigned FRAME_BYTES = 5;
    localparam int unsigned FRAME_BITS  = FRAME_BYTES * 8;
    localparam int unsigned CNT_W       = 6;

    // s_tdata: opcode [1:0], low_time [17:2], period_time [33:18], zero pad
    localparam int unsigned IN_TDATA_W  = 40;
    // m_tdata: status [2:0], humidity [18:3], temperature [34:19],
    //          narrow_format [35], zero pad
    localparam int unsigned OUT_TDATA_W = 40;

    // Reset values of the nominal timings, in microseconds
    localparam int unsigned RST_START_LOW  = 100;
    localparam int unsigned RST_START_HIGH = 80;
    localparam int unsigned RST_BIT_LOW    = 60;
    localparam int unsigned RST_ZERO_HIGH  = 26;
    localparam int unsigned RST_ONE_HIGH   = 70;

    // Reciprocal used to take the tolerance out of a 12-bit nominal
    localparam int unsigned RECIP_SHIFT = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_LOW  = 3'd0,
        REG_START_HIGH = 3'd1,
        REG_BIT_LOW    = 3'd2,
        REG_ZERO_HIGH  = 3'd3,
        REG_ONE_HIGH   = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_BEGIN    = 2'd0,
        OP_PULSE    = 2'd1,
        OP_OVERFLOW = 2'd2,
        OP_TIMEOUT  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TIMEOUT   = 3'd1,
        ST_NO_PERIOD = 3'd2,
        ST_DECODE    = 3'd3,
        ST_CHECKSUM  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    // low in [nom - dlt, nom + dlt) and high = period - low in the same
    // kind of window around its own nominal; a negative high fails.
    function automatic logic in_window(
        input logic [TIME_W-1:0] low_t,
        input logic [TIME_W-1:0] period_t,
        input logic [CFG_W-1:0]  low_nom,
        input logic [CFG_W-1:0]  low_dlt,
        input logic [CFG_W-1:0]  high_nom,
        input logic [CFG_W-1:0]  high_dlt
    );
        logic signed [17:0] lo;
        logic signed [17:0] hi;
        logic signed [17:0] lmin;
        logic signed [17:0] lmax;
        logic signed [17:0] hmin;
        logic signed [17:0] hmax;
        lo   = $signed({2'b00, low_t});
        hi   = $signed({2'b00, period_t}) - $signed({2'b00, low_t});
        lmin = $signed({6'd0, low_nom}) - $signed({6'd0, low_dlt});
        lmax = $signed({6'd0, low_nom}) + $signed({6'd0, low_dlt});
        hmin = $signed({6'd0, high_nom}) - $signed({6'd0, high_dlt});
        hmax = $signed({6'd0, high_nom}) + $signed({6'd0, high_dlt});
        return (lo >= lmin) && (lo < lmax) && (hi >= hmin) && (hi < hmax);
    endfunction

endpackage

FILE: hw/rtl/humidity_sensor_pulse_decoder.sv
`timescale 1ns / 1ps
// ============================================================================
// humidity_sensor_pulse_decoder
// Decodes measured pulse times of a single-wire humidity sensor into one
// humidity and temperature reading per read.
// ============================================================================
// Takes one word per clock. A begin word arms a read; the first pulse must
// fit the start window, the next 40 pulses are sorted into one and zero bits,
// and the last of them (or a timeout word, or a word that fits no window)
// yields one result word with status, humidity, temperature and a
// narrow-format flag. Each word passes the input register, then the window
// compares, shift and checksum logic into the result register. While a result
// word waits, one more word is taken into the input register and the input then
// stalls until the result word leaves. Tolerances
// are nominal / TOLERANCE_DIVISOR, formed by a reciprocal multiply at
// register write time, so a new setting applies to the next word.
module humidity_sensor_pulse_decoder #(
    parameter int unsigned TOLERANCE_DIVISOR = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // opcode [1:0], low_time [17:2], period_time [33:18]
    input  logic [hspd_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // status [2:0], humidity [18:3], temperature [34:19], narrow_format [35]
    output logic [hspd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hspd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hspd_pkg::CFG_W-1:0]           cfg_data
);
    import hspd_pkg::*;

    localparam int unsigned RECIP_W = RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + TOLERANCE_DIVISOR - 1) / TOLERANCE_DIVISOR);
    localparam int unsigned PROD_W = CFG_W + RECIP_W;

    function automatic logic [CFG_W-1:0] tol_of(input logic [CFG_W-1:0] v);
        logic [PROD_W-1:0] p;
        p = {{RECIP_W{1'b0}}, v} * {{CFG_W{1'b0}}, RECIP};
        return p[PROD_W-1:RECIP_SHIFT];
    endfunction

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] start_low_reg, start_high_reg, bit_low_reg, zero_high_reg, one_high_reg;
    logic [CFG_W-1:0] start_low_tol_reg, start_high_tol_reg, bit_low_tol_reg;
    logic [CFG_W-1:0] zero_high_tol_reg, one_high_tol_reg;
    logic [CFG_W-1:0] cfg_tol;

    assign cfg_ready = 1'b1;
    assign cfg_tol   = tol_of(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_low_reg      <= CFG_W'(RST_START_LOW);
            start_high_reg     <= CFG_W'(RST_START_HIGH);
            bit_low_reg        <= CFG_W'(RST_BIT_LOW);
            zero_high_reg      <= CFG_W'(RST_ZERO_HIGH);
            one_high_reg       <= CFG_W'(RST_ONE_HIGH);
            start_low_tol_reg  <= CFG_W'(RST_START_LOW / TOLERANCE_DIVISOR);
            start_high_tol_reg <= CFG_W'(RST_START_HIGH / TOLERANCE_DIVISOR);
            bit_low_tol_reg    <= CFG_W'(RST_BIT_LOW / TOLERANCE_DIVISOR);
            zero_high_tol_reg  <= CFG_W'(RST_ZERO_HIGH / TOLERANCE_DIVISOR);
            one_high_tol_reg   <= CFG_W'(RST_ONE_HIGH / TOLERANCE_DIVISOR);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_START_LOW:
                begin
                    start_low_reg     <= cfg_data;
                    start_low_tol_reg <= cfg_tol;
                end
                REG_START_HIGH:
                begin
                    start_high_reg     <= cfg_data;
                    start_high_tol_reg <= cfg_tol;
                end
                REG_BIT_LOW:
                begin
                    bit_low_reg     <= cfg_data;
                    bit_low_tol_reg <= cfg_tol;
                end
                REG_ZERO_HIGH:
                begin
                    zero_high_reg     <= cfg_data;
                    zero_high_tol_reg <= cfg_tol;
                end
                REG_ONE_HIGH:
                begin
                    one_high_reg     <= cfg_data;
                    one_high_tol_reg <= cfg_tol;
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                in_valid_reg;
    opcode_t             op_reg;
    logic [TIME_W-1:0]   low_reg;
    logic [TIME_W-1:0]   period_reg;
    logic                fire;
    logic                out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg     <= opcode_t'(s_tdata[1:0]);
            low_reg    <= s_tdata[17:2];
            period_reg <= s_tdata[33:18];
        end
    end

    // ---------------- decode ----------------
    phase_t                phase_reg, phase_next;
    logic [CNT_W-1:0]      bits_reg, bits_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [TIME_W-1:0]     last_period_reg, last_period_next;

    logic                  res_valid;
    status_t               res_status;
    logic [15:0]           res_hum;
    logic [15:0]           res_temp;
    logic                  res_narrow;

    logic [TIME_W-1:0]     cur_low;
    logic [TIME_W-1:0]     cur_period;
    logic                  win_start, win_one, win_zero;
    logic [FRAME_BITS-1:0] shifted;
    logic [CNT_W-1:0]      bits_inc;
    logic [7:0]            b0, b1, b2, b3, b4, csum;
    logic [15:0]           raw_temp;

    assign cur_low    = (op_reg == OP_PULSE) ? low_reg : '0;
    assign cur_period = (op_reg == OP_PULSE) ? period_reg : last_period_reg;

    assign win_start = in_window(cur_low, cur_period, start_low_reg, start_low_tol_reg,
                                 start_high_reg, start_high_tol_reg);
    assign win_one   = in_window(cur_low, cur_period, bit_low_reg, bit_low_tol_reg,
                                 one_high_reg, one_high_tol_reg);
    assign win_zero  = in_window(cur_low, cur_period, bit_low_reg, bit_low_tol_reg,
                                 zero_high_reg, zero_high_tol_reg);

    assign shifted  = {shift_reg[FRAME_BITS-2:0], win_one};
    assign bits_inc = bits_reg + CNT_W'(1);

    // bytes of the frame as it stands after this bit, byte 0 received first
    assign b0       = shifted[39:32];
    assign b1       = shifted[31:24];
    assign b2       = shifted[23:16];
    assign b3       = shifted[15:8];
    assign b4       = shifted[7:0];
    assign csum     = b0 + b1 + b2 + b3;
    assign raw_temp = {b2, b3};

    always_comb
    begin
        phase_next       = phase_reg;
        bits_next        = bits_reg;
        shift_next       = shift_reg;
        last_period_next = last_period_reg;
        res_valid        = 1'b0;
        res_status       = ST_OK;
        res_hum          = '0;
        res_temp         = '0;
        res_narrow       = 1'b0;

        if (fire)
        begin
            if (op_reg == OP_BEGIN)
            begin
                // restart the read, dropping any partial frame
                phase_next       = PH_START;
                bits_next        = '0;
                shift_next       = '0;
                last_period_next = '0;
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (op_reg == OP_PULSE)
                begin
                    last_period_next = period_reg;
                end
                if (op_reg == OP_TIMEOUT)
                begin
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    res_status = ST_TIMEOUT;
                end
                else if (phase_reg == PH_START)
                begin
                    if (cur_period == '0)
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_status = ST_NO_PERIOD;
                    end
                    else if (!win_start)
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_status = ST_DECODE;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        bits_next  = '0;
                        shift_next = '0;
                    end
                end
                else if (!win_one && !win_zero)
                begin
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    res_status = ST_DECODE;
                end
                else
                begin
                    shift_next = shifted;
                    bits_next  = bits_inc;
                    if (bits_inc >= CNT_W'(FRAME_BITS))
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        if (csum != b4)
                        begin
                            res_status = ST_CHECKSUM;
                        end
                        else if (b1 == 8'd0 && b3 == 8'd0)
                        begin
                            res_hum    = {8'd0, b0};
                            res_temp   = {8'd0, b2};
                            res_narrow = 1'b1;
                        end
                        else
                        begin
                            res_hum  = {b0, b1};
                            // sign-magnitude to two's complement
                            res_temp = raw_temp[15] ? (16'd0 - {1'b0, raw_temp[14:0]})
                                                    : raw_temp;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bits_reg        <= '0;
            shift_reg       <= '0;
            last_period_reg <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            bits_reg        <= bits_next;
            shift_reg       <= shift_next;
            last_period_reg <= last_period_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= {4'd0, res_narrow, res_temp, res_hum, res_status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: hw/rtl/hspd_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// hspd_checker
// Port-level checks on the result stream of the pulse decoder.
// ============================================================================
module hspd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [hspd_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import hspd_pkg::*;

    // hold a stalled result word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] == ST_OK) || (m_tdata[2:0] == ST_TIMEOUT) ||
                     (m_tdata[2:0] == ST_NO_PERIOD) || (m_tdata[2:0] == ST_DECODE) ||
                     (m_tdata[2:0] == ST_CHECKSUM))
        else $error("status out of range");

    // failed reads carry no reading
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] != ST_OK) |-> (m_tdata[35:3] == '0))
        else $error("failed read carries data");

    // narrow readings are single bytes of an ok read
    a_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[35] |->
            (m_tdata[2:0] == ST_OK) && (m_tdata[18:11] == 8'd0) && (m_tdata[34:27] == 8'd0))
        else $error("narrow reading out of byte range");

endmodule

bind humidity_sensor_pulse_decoder hspd_checker u_hspd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/sv/humidity_sensor_pulse_decoder_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// humidity_sensor_pulse_decoder_tb
// Self-checking bench for the pulse decoder: a queue-fed driver sends begin,
// pulse, overflow and timeout words, a predictor works out each reading, and
// a monitor compares every result word field by field, across several timing
// settings and sender/receiver idle mixes.
// ============================================================================
module humidity_sensor_pulse_decoder_tb;
    import hspd_pkg::*;

    localparam int TOL_DIV      = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_WORDS  = 195;

    typedef struct {
        opcode_t          op;
        logic [TIME_W-1:0] low_t;
        logic [TIME_W-1:0] per_t;
    } sensor_word_t;

    typedef struct {
        status_t            status;
        logic [15:0]        humidity;
        logic signed [15:0] temperature;
        logic               narrow;
    } reading_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;

    sensor_word_t pending_words[$];
    reading_t     expected_readings[$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;

    // Predictor copy of the timing registers and the read state
    logic [CFG_W-1:0] nom_start_low  = CFG_W'(RST_START_LOW);
    logic [CFG_W-1:0] nom_start_high = CFG_W'(RST_START_HIGH);
    logic [CFG_W-1:0] nom_bit_low    = CFG_W'(RST_BIT_LOW);
    logic [CFG_W-1:0] nom_zero_high  = CFG_W'(RST_ZERO_HIGH);
    logic [CFG_W-1:0] nom_one_high   = CFG_W'(RST_ONE_HIGH);
    phase_t           rx_phase       = PH_IDLE;
    int               bit_count      = 0;
    logic [39:0]      frame_bits     = '0;
    logic [TIME_W-1:0] held_period   = '0;

    humidity_sensor_pulse_decoder #(
        .TOLERANCE_DIVISOR(TOL_DIV)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100)
            $display("ERROR %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic bit pulse_fits(input int lo_t, input int per_t, input int nl,
                                      input int nh);
        int hi_t;
        int dl;
        int dh;
        hi_t = per_t - lo_t;
        dl   = nl / TOL_DIV;
        dh   = nh / TOL_DIV;
        return lo_t >= nl - dl && lo_t < nl + dl && hi_t >= nh - dh && hi_t < nh + dh;
    endfunction

    task automatic end_read(input status_t st);
        expected_readings.push_back('{st, 16'd0, 16'sd0, 1'b0});
        rx_phase = PH_IDLE;
    endtask

    task automatic decode_frame();
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  sum;
        logic [15:0] raw;
        logic [15:0] temp;
        {b0, b1, b2, b3} = frame_bits[39:8];
        sum = b0 + b1 + b2 + b3;
        if (sum != frame_bits[7:0])
        begin
            end_read(ST_CHECKSUM);
            return;
        end
        rx_phase = PH_IDLE;
        if (b1 == 8'd0 && b3 == 8'd0)
        begin
            expected_readings.push_back('{ST_OK, {8'd0, b0}, {8'd0, b2}, 1'b1});
            return;
        end
        raw  = {b2, b3};
        // sign-magnitude: bit 15 is the sign, the low 15 bits the magnitude
        temp = raw[15] ? 16'd0 - {1'b0, raw[14:0]} : raw;
        expected_readings.push_back('{ST_OK, {b0, b1}, temp, 1'b0});
    endtask

    task automatic predict_reading(input sensor_word_t w);
        int cur_low;
        if (w.op == OP_BEGIN)
        begin
            rx_phase    = PH_START;
            bit_count   = 0;
            frame_bits  = '0;
            held_period = '0;
            return;
        end
        if (rx_phase == PH_IDLE)
            return;
        if (w.op == OP_TIMEOUT)
        begin
            end_read(ST_TIMEOUT);
            return;
        end
        // overflow reuses the last captured period with a zero low time
        if (w.op == OP_PULSE)
        begin
            held_period = w.per_t;
            cur_low     = int'(w.low_t);
        end
        else
            cur_low = 0;
        if (rx_phase == PH_START)
        begin
            if (held_period == 0)
                end_read(ST_NO_PERIOD);
            else if (!pulse_fits(cur_low, int'(held_period), int'(nom_start_low),
                                 int'(nom_start_high)))
                end_read(ST_DECODE);
            else
            begin
                rx_phase   = PH_DATA;
                bit_count  = 0;
                frame_bits = '0;
            end
            return;
        end
        if (pulse_fits(cur_low, int'(held_period), int'(nom_bit_low), int'(nom_one_high)))
            frame_bits = {frame_bits[38:0], 1'b1};
        else if (pulse_fits(cur_low, int'(held_period), int'(nom_bit_low),
                            int'(nom_zero_high)))
            frame_bits = {frame_bits[38:0], 1'b0};
        else
        begin
            end_read(ST_DECODE);
            return;
        end
        bit_count++;
        if (bit_count >= FRAME_BITS)
            decode_frame();
    endtask

    task automatic check_reading(input logic [OUT_TDATA_W-1:0] word);
        reading_t    want;
        logic [2:0]  got_status;
        logic [15:0] got_hum;
        logic [15:0] got_temp;
        logic        got_narrow;
        got_status = word[2:0];
        got_hum    = word[18:3];
        got_temp   = word[34:19];
        got_narrow = word[35];
        if (expected_readings.size() == 0)
        begin
            report_mismatch($sformatf("unexpected reading, status %0d", got_status));
            return;
        end
        want = expected_readings.pop_front();
        if (got_status !== want.status || got_hum !== want.humidity
            || got_temp !== want.temperature || got_narrow !== want.narrow)
            report_mismatch($sformatf(
                "got st %0d hum %0d temp %0d nar %0b, want st %0d hum %0d temp %0d nar %0b",
                got_status, got_hum, $signed(got_temp), got_narrow,
                want.status, want.humidity, want.temperature, want.narrow));
    endtask

    // Sender: hold the front word until taken, then advance
    always @(posedge clk or negedge rst_n)
    begin
        logic presenting;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            presenting = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                predict_reading(pending_words.pop_front());
                presenting = 1'b0;
            end
            if (!presenting && pending_words.size() != 0
                && $urandom_range(99) >= send_idle_pct)
                presenting = 1'b1;
            s_tvalid <= presenting;
            if (presenting)
                s_tdata <= {6'd0, pending_words[0].per_t, pending_words[0].low_t,
                            pending_words[0].op};
        end
    end

    // Receiver: check each result word, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_reading(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_word(input opcode_t op, input int lo_t, input int per_t);
        pending_words.push_back('{op, 16'(lo_t), 16'(per_t)});
    endtask

    // Mostly inside the window, some on its edges, rarely just outside
    function automatic int pick_in_window(input int nom);
        int dlt;
        int roll;
        dlt = nom / TOL_DIV;
        if (dlt == 0)
            return nom;
        roll = $urandom_range(0, 999);
        if (roll == 0)
            return nom + dlt;
        if (roll == 1)
            return nom - dlt - 1;
        if (roll < 20)
            return nom - dlt;
        if (roll < 40)
            return nom + dlt - 1;
        return nom - dlt + $urandom_range(0, 2 * dlt - 1);
    endfunction

    task automatic push_pulse(input int nl, input int nh);
        int lo_t;
        int hi_t;
        lo_t = pick_in_window(nl);
        hi_t = pick_in_window(nh);
        push_word(OP_PULSE, lo_t, lo_t + hi_t);
    endtask

    task automatic push_break();
        case ($urandom_range(0, 3))
            0: push_word(OP_TIMEOUT, $urandom, $urandom);
            1: push_word(OP_OVERFLOW, $urandom, $urandom);
            2: push_word(OP_BEGIN, $urandom, $urandom);
            default: push_word(OP_PULSE, $urandom, $urandom);
        endcase
    endtask

    // kind: 0 narrow, 1 wide positive, 2 wide negative, 3 bad checksum,
    //       4 cut short, other fully random bytes
    task automatic queue_read(input int kind, output int words);
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  b4;
        logic [39:0] frame;
        int          cut;
        b0 = 8'($urandom);
        b1 = 8'($urandom);
        b2 = 8'($urandom);
        b3 = 8'($urandom);
        case (kind)
            0:
            begin
                b1 = 8'd0;
                b3 = 8'd0;
            end
            1: b2[7] = 1'b0;
            2: b2[7] = 1'b1;
            default: ;
        endcase
        b4 = b0 + b1 + b2 + b3;
        if (kind == 3)
            b4 = b4 ^ 8'($urandom_range(1, 255));
        frame = {b0, b1, b2, b3, b4};
        cut   = (kind == 4) ? $urandom_range(0, FRAME_BITS) : -1;
        words = 1;
        push_word(OP_BEGIN, $urandom, $urandom);
        for (int i = 0; i <= FRAME_BITS; i++)
        begin
            words++;
            if (i == cut)
            begin
                push_break();
                return;
            end
            if (i == 0)
                push_pulse(int'(nom_start_low), int'(nom_start_high));
            else
                push_pulse(int'(nom_bit_low), frame[6'(FRAME_BITS - i)] ?
                           int'(nom_one_high) : int'(nom_zero_high));
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_reads(input bit lead_kinds);
        int words;
        int queued;
        int n;
        int roll;
        int kind;
        queued = 0;
        n      = 0;
        while (queued < PHASE_WORDS)
        begin
            // stray words between reads
            if ($urandom_range(0, 9) == 0)
            begin
                push_word(opcode_t'($urandom_range(1, 3)), $urandom, $urandom);
                queued++;
            end
            roll = $urandom_range(0, 9);
            kind = (roll < 4) ? roll : (roll < 6) ? 4 : 5;
            if (lead_kinds && n < 4)
                kind = n;
            queue_read(kind, words);
            queued += words;
            n++;
        end
        wait_drained();
    endtask

    task automatic write_timing(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_START_LOW:  nom_start_low  = val;
            REG_START_HIGH: nom_start_high = val;
            REG_BIT_LOW:    nom_bit_low    = val;
            REG_ZERO_HIGH:  nom_zero_high  = val;
            REG_ONE_HIGH:   nom_one_high   = val;
            default: ;
        endcase
    endtask

    task automatic set_timings(input int sl, input int sh, input int bl, input int zh,
                               input int oh);
        write_timing(REG_START_LOW, CFG_W'(sl));
        write_timing(REG_START_HIGH, CFG_W'(sh));
        write_timing(REG_BIT_LOW, CFG_W'(bl));
        write_timing(REG_ZERO_HIGH, CFG_W'(zh));
        write_timing(REG_ONE_HIGH, CFG_W'(oh));
    endtask

    initial
    begin
        int zh;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 71;
        // Words while idle are dropped
        push_word(OP_TIMEOUT, 0, 0);
        push_word(OP_PULSE, 'hFFFF, 'hFFFF);
        push_word(OP_OVERFLOW, 0, 0);
        // Timeout right after begin
        push_word(OP_BEGIN, 0, 0);
        push_word(OP_TIMEOUT, 'hFFFF, 'hFFFF);
        // Overflow as the start pulse: no period yet
        push_word(OP_BEGIN, 'hFFFF, 'hFFFF);
        push_word(OP_OVERFLOW, 'hFFFF, 'hFFFF);
        // Zero period at the start pulse
        push_word(OP_BEGIN, 0, 0);
        push_word(OP_PULSE, 100, 0);
        // Begin again mid-read restarts silently
        push_word(OP_BEGIN, 0, 0);
        push_word(OP_BEGIN, 0, 0);
        push_word(OP_PULSE, 'hFFFF, 'hFFFF);
        // Period shorter than low: negative high time
        push_word(OP_BEGIN, 0, 0);
        push_word(OP_PULSE, 100, 50);
        // Overflow on a data bit
        push_word(OP_BEGIN, 0, 0);
        push_word(OP_PULSE, 100, 180);
        push_word(OP_OVERFLOW, 0, 0);
        // A one and a zero, then a timeout
        push_word(OP_BEGIN, 0, 0);
        push_word(OP_PULSE, 100, 180);
        push_word(OP_PULSE, 60, 130);
        push_word(OP_PULSE, 60, 86);
        push_word(OP_TIMEOUT, 0, 0);
        // Zero low time with the largest period
        push_word(OP_BEGIN, 0, 0);
        push_word(OP_PULSE, 0, 'hFFFF);
        wait_drained();

        run_reads(1'b1);

        set_timings(0, 0, 0, 0, 0);
        run_reads(1'b0);

        send_idle_pct = 71;
        recv_idle_pct = 24;
        set_timings(4095, 4095, 4095, 4095, 4095);
        run_reads(1'b0);

        zh = $urandom_range(8, 60);
        set_timings($urandom_range(40, 400), $urandom_range(40, 400),
                    $urandom_range(20, 200), zh, 2 * zh + $urandom_range(8, 60));
        run_reads(1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_timings(RST_START_LOW, RST_START_HIGH, RST_BIT_LOW, RST_ZERO_HIGH,
                    RST_ONE_HIGH);
        run_reads(1'b0);

        set_timings($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095));
        run_reads(1'b0);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/hspd_pkg.sv
hw/rtl/humidity_sensor_pulse_decoder.sv
hw/rtl/hspd_checker.sv
tb/sv/humidity_sensor_pulse_decoder_tb.sv
